@@ src/cbq_pkg.sv @@
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared widths, codes and the control-word program of the cascaded biquad
// filter core.
// ----------------------------------------------------------------------------
package cbq_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int COEF_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = DATA_W + COEF_W;
  // five products of PROD_W bits need three guard bits
  localparam int ACC_W      = PROD_W + 3;
  localparam int FF_W       = 3 * COEF_W;
  localparam int FB_W       = 2 * COEF_W;
  localparam int CFG_DATA_W = FF_W;
  localparam int UC_STEPS   = 14;
  localparam int STEP_W     = $clog2(UC_STEPS);

  localparam logic [FF_W-1:0] FF_RESET = FF_W'(1 << FRAC_BITS);
  localparam logic [FB_W-1:0] FB_RESET = '0;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    CFG_FIRST_FF  = 2'd0,
    CFG_FIRST_FB  = 2'd1,
    CFG_SECOND_FF = 2'd2,
    CFG_SECOND_FB = 2'd3
  } cfg_idx_t;

  // multiplier data operand
  typedef enum logic [3:0] {
    A_X0  = 4'd0,
    A_X1  = 4'd1,
    A_X2  = 4'd2,
    A_Y1  = 4'd3,
    A_Y2  = 4'd4,
    A_ACC = 4'd5,
    A_S1  = 4'd6,
    A_S2  = 4'd7,
    A_Z1  = 4'd8,
    A_Z2  = 4'd9
  } opa_sel_t;

  // multiplier coefficient operand
  typedef enum logic [3:0] {
    C_B0 = 4'd0,
    C_B1 = 4'd1,
    C_B2 = 4'd2,
    C_A0 = 4'd3,
    C_A1 = 4'd4,
    C_B3 = 4'd5,
    C_B4 = 4'd6,
    C_B5 = 4'd7,
    C_A2 = 4'd8,
    C_A3 = 4'd9
  } coef_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    WB_NONE   = 2'd0,
    WB_FIRST  = 2'd1,
    WB_SECOND = 2'd2
  } wb_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT    = 2'd0,
    SEQ_WAIT_IN = 2'd1,
    SEQ_FINISH  = 2'd2
  } seq_op_t;

  typedef struct packed {
    opa_sel_t  opa;
    coef_sel_t coef;
    logic      mul_en;
    acc_op_t   acc;
    wb_op_t    wb;
    seq_op_t   seq;
  } ucode_t;

  localparam ucode_t UC_IDLE = '{A_X0, C_B0, 1'b0, ACC_HOLD, WB_NONE, SEQ_WAIT_IN};

  // control store: stage one MACs, hand-off, stage two MACs, write back
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    uc = UC_IDLE;
    unique case (step)
      STEP_W'(0):  uc = UC_IDLE;
      STEP_W'(1):  uc = '{A_X0,  C_B0, 1'b1, ACC_HOLD, WB_NONE,   SEQ_NEXT};
      STEP_W'(2):  uc = '{A_X1,  C_B1, 1'b1, ACC_LOAD, WB_NONE,   SEQ_NEXT};
      STEP_W'(3):  uc = '{A_X2,  C_B2, 1'b1, ACC_ADD,  WB_NONE,   SEQ_NEXT};
      STEP_W'(4):  uc = '{A_Y1,  C_A0, 1'b1, ACC_ADD,  WB_NONE,   SEQ_NEXT};
      STEP_W'(5):  uc = '{A_Y2,  C_A1, 1'b1, ACC_ADD,  WB_NONE,   SEQ_NEXT};
      STEP_W'(6):  uc = '{A_X0,  C_B0, 1'b0, ACC_ADD,  WB_NONE,   SEQ_NEXT};
      STEP_W'(7):  uc = '{A_ACC, C_B3, 1'b1, ACC_HOLD, WB_FIRST,  SEQ_NEXT};
      STEP_W'(8):  uc = '{A_S1,  C_B4, 1'b1, ACC_LOAD, WB_NONE,   SEQ_NEXT};
      STEP_W'(9):  uc = '{A_S2,  C_B5, 1'b1, ACC_ADD,  WB_NONE,   SEQ_NEXT};
      STEP_W'(10): uc = '{A_Z1,  C_A2, 1'b1, ACC_ADD,  WB_NONE,   SEQ_NEXT};
      STEP_W'(11): uc = '{A_Z2,  C_A3, 1'b1, ACC_ADD,  WB_NONE,   SEQ_NEXT};
      STEP_W'(12): uc = '{A_X0,  C_B0, 1'b0, ACC_ADD,  WB_NONE,   SEQ_NEXT};
      STEP_W'(13): uc = '{A_X0,  C_B0, 1'b0, ACC_HOLD, WB_SECOND, SEQ_FINISH};
      default:     uc = UC_IDLE;
    endcase
    return uc;
  endfunction

endpackage

@@ src/cbq_if.sv @@
// ----------------------------------------------------------------------------
// cbq_in_if / cbq_out_if
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
interface cbq_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cbq_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface cbq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cbq_pkg::DATA_W-1:0] filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink (input valid, input filtered_out, output ready);
endinterface

@@ src/cascaded_biquad_q14_filter_core.sv @@
// ----------------------------------------------------------------------------
// cascaded_biquad_q14_filter_core
// Fourth-order IIR: two direct-form-I biquads with Q14 coefficients, run by
// a small control-word program over one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+---------------------------------
//  in_ch    | in  | valid/ready       | sample_in    (signed 16)
//  out_ch   | out | valid/ready       | filtered_out (signed 32)
//  cfg_*    | in  | cfg_wr_en only    | cfg_index (2), cfg_wdata (48)
//
//  Each item runs through the step counter: an accept step, ten
//  registered multiplies on the one 32x16 multiplier, a drain step after each
//  section and a final write-back (stage one writes back during step seven).
//  Reset clears the step counter, delay lines and output valid flag, and loads
//  unity feedforward, zero feedback; input ready stays low while in reset.
//  A waiting result does not block the next item; only the write-back holds.
// ----------------------------------------------------------------------------
module cascaded_biquad_q14_filter_core (
  input  logic                             clk,
  input  logic                             rst_n,
  cbq_in_if.sink                           in_ch,
  cbq_out_if.source                        out_ch,
  input  logic                             cfg_wr_en,
  input  cbq_pkg::cfg_idx_t                cfg_index,
  input  logic [cbq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import cbq_pkg::*;

  // coefficient registers
  logic [FF_W-1:0] first_ff_r, second_ff_r;
  logic [FB_W-1:0] first_fb_r, second_fb_r;

  // sequencer
  step_t  step_r, step_nxt;
  ucode_t uc;

  // delay lines
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] x1_r, x2_r;
  logic signed [DATA_W-1:0]   y1_r, y2_r;
  logic signed [DATA_W-1:0]   s1_r, s2_r;
  logic signed [DATA_W-1:0]   z1_r, z2_r;

  // datapath
  logic signed [DATA_W-1:0] opa;
  logic signed [COEF_W-1:0] opc;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [DATA_W-1:0] acc_scaled;

  // output register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_data_r;

  logic in_fire;
  logic out_free;
  logic advance;

  assign uc        = ucode_rom(step_r);
  assign in_ch.ready = rst_n && (uc.seq == SEQ_WAIT_IN);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.filtered_out = out_data_r;

  // arithmetic shift right by FRAC_BITS, keep the low 32 bits (wraps)
  assign acc_scaled = acc_r[FRAC_BITS +: DATA_W];
  assign prod_ext   = ACC_W'(prod_r);

  // step control: wait for an item, run the program, hold at the end while
  // the output register is occupied
  always_comb begin
    step_nxt = step_r;
    advance  = 1'b0;
    unique case (uc.seq)
      SEQ_NEXT: begin
        step_nxt = step_r + STEP_W'(1);
        advance  = 1'b1;
      end
      SEQ_WAIT_IN: begin
        if (in_fire) begin
          step_nxt = step_r + STEP_W'(1);
          advance  = 1'b1;
        end
      end
      SEQ_FINISH: begin
        if (out_free) begin
          step_nxt = '0;
          advance  = 1'b1;
        end
      end
      default: begin
        step_nxt = '0;
      end
    endcase
  end

  // multiplier data operand, 16-bit samples sign-extended
  always_comb begin
    unique case (uc.opa)
      A_X0:    opa = {{(DATA_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
      A_X1:    opa = {{(DATA_W-SAMPLE_W){x1_r[SAMPLE_W-1]}}, x1_r};
      A_X2:    opa = {{(DATA_W-SAMPLE_W){x2_r[SAMPLE_W-1]}}, x2_r};
      A_Y1:    opa = y1_r;
      A_Y2:    opa = y2_r;
      A_ACC:   opa = acc_scaled;
      A_S1:    opa = s1_r;
      A_S2:    opa = s2_r;
      A_Z1:    opa = z1_r;
      A_Z2:    opa = z2_r;
      default: opa = '0;
    endcase
  end

  // coefficient operand, picked out of the packed registers
  always_comb begin
    unique case (uc.coef)
      C_B0:    opc = first_ff_r[0*COEF_W +: COEF_W];
      C_B1:    opc = first_ff_r[1*COEF_W +: COEF_W];
      C_B2:    opc = first_ff_r[2*COEF_W +: COEF_W];
      C_A0:    opc = first_fb_r[0*COEF_W +: COEF_W];
      C_A1:    opc = first_fb_r[1*COEF_W +: COEF_W];
      C_B3:    opc = second_ff_r[0*COEF_W +: COEF_W];
      C_B4:    opc = second_ff_r[1*COEF_W +: COEF_W];
      C_B5:    opc = second_ff_r[2*COEF_W +: COEF_W];
      C_A2:    opc = second_fb_r[0*COEF_W +: COEF_W];
      C_A3:    opc = second_fb_r[1*COEF_W +: COEF_W];
      default: opc = '0;
    endcase
  end

  // control state and coefficients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
      first_ff_r  <= FF_RESET;
      first_fb_r  <= FB_RESET;
      second_ff_r <= FF_RESET;
      second_fb_r <= FB_RESET;
    end else begin
      step_r <= step_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_FIRST_FF:  first_ff_r  <= cfg_wdata[FF_W-1:0];
          CFG_FIRST_FB:  first_fb_r  <= cfg_wdata[FB_W-1:0];
          CFG_SECOND_FF: second_ff_r <= cfg_wdata[FF_W-1:0];
          CFG_SECOND_FB: second_fb_r <= cfg_wdata[FB_W-1:0];
        endcase
      end
      // drop the valid flag when taken, raise it on the final write-back
      if (uc.wb == WB_SECOND && advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // delay lines are filter state and clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
      s1_r <= '0;
      s2_r <= '0;
      z1_r <= '0;
      z2_r <= '0;
    end else begin
      if (uc.wb == WB_FIRST && advance) begin
        x2_r <= x1_r;
        x1_r <= sample_r;
        y2_r <= y1_r;
        y1_r <= acc_scaled;
      end
      if (uc.wb == WB_SECOND && advance) begin
        s2_r <= s1_r;
        s1_r <= y1_r;
        z2_r <= z1_r;
        z1_r <= acc_scaled;
      end
    end
  end

  // payload registers: sample latch, MAC unit, result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_ch.sample_in;
    end
    if (uc.mul_en) begin
      prod_r <= opa * opc;
    end
    unique case (uc.acc)
      ACC_LOAD: acc_r <= prod_ext;
      ACC_ADD:  acc_r <= acc_r + prod_ext;
      ACC_HOLD: acc_r <= acc_r;
      default:  acc_r <= acc_r;
    endcase
    if (uc.wb == WB_SECOND && advance) begin
      out_data_r <= acc_scaled;
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Regression for the cascaded biquad filter core. It drives input samples,
// coefficient writes and output back-pressure, runs a bit-exact fourth-order
// Q14 filter alongside the core and compares every filtered sample in order.
// ----------------------------------------------------------------------------
module testbench;
  import cbq_pkg::*;

  // Quiet cycles allowed before the run is declared hung. This covers the
  // long receiver hold-off plus the sparse stall modes with a wide margin.
  localparam int WATCHDOG_LIMIT  = 3000;
  // Covers one item's run through the core, with a margin on top of that
  localparam int DRAIN_CYCLES    = 24;
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLDOFF_PHASE   = 3;
  localparam int MAX_REPORTS     = 40;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_t;

  // how the coefficients of one random phase are chosen
  typedef enum logic [1:0] {
    SET_RANDOM,
    SET_MILD,
    SET_EXTREME,
    SET_SINGLE_TAP
  } setting_kind_t;

  // back-pressure patterns of the result receiver
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN,
    READY_SPARSE
  } stall_mode_t;

  typedef struct packed {
    row_kind_t                  kind;
    cfg_idx_t                   reg_sel;
    logic [CFG_DATA_W-1:0]      value;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       typed;
    logic signed [DATA_W-1:0]   typed_out;
  } stim_row_t;

  // Directed stimulus. A row either writes one coefficient register or sends
  // one sample. Rows with typed set carry an expectation that is obvious by
  // inspection (unity pass-through after reset, silence with zero taps);
  // all other samples are checked against the filter model below.
  localparam stim_row_t DIRECTED_ROWS [0:38] = '{
    // reset setting: unity feedforward, no feedback, so output equals input
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh0000, 1'b1, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh7FFF, 1'b1, 32'sd32767},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh8000, 1'b1, -32'sd32768},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh0001, 1'b1, 32'sd1},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'shFFFF, 1'b1, -32'sd1},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh5555, 1'b1, 32'sd21845},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'shAAAA, 1'b1, -32'sd21846},
    // all taps zero; junk above bit 31 of the feedback words must be dropped
    '{ROW_WRITE,  CFG_FIRST_FF,  48'h0000_0000_0000, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FIRST_FB,  48'hFFFF_0000_0000, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_SECOND_FF, 48'h0000_0000_0000, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_SECOND_FB, 48'h5A5A_0000_0000, 16'sh0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh7FFF, 1'b1, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh8000, 1'b1, 32'sd0},
    // most negative taps everywhere: widest products, output wraps
    '{ROW_WRITE,  CFG_FIRST_FF,  48'h8000_8000_8000, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FIRST_FB,  48'hFFFF_8000_8000, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_SECOND_FF, 48'h8000_8000_8000, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_SECOND_FB, 48'h0000_8000_8000, 16'sh0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh8000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh8000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh8000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh7FFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh7FFF, 1'b0, 32'sd0},
    // most positive taps everywhere
    '{ROW_WRITE,  CFG_FIRST_FF,  48'h7FFF_7FFF_7FFF, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FIRST_FB,  48'h0000_7FFF_7FFF, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_SECOND_FF, 48'h7FFF_7FFF_7FFF, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_SECOND_FB, 48'hFFFF_7FFF_7FFF, 16'sh0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh7FFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh7FFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh7FFF, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh8000, 1'b0, 32'sd0},
    // low-pass sections with real feedback, excited by a unit impulse
    '{ROW_WRITE,  CFG_FIRST_FF,  48'h1000_2000_1000, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_FIRST_FB,  48'h0000_DCD8_5DC0, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_SECOND_FF, 48'h1000_2000_1000, 16'sh0, 1'b0, 32'sd0},
    '{ROW_WRITE,  CFG_SECOND_FB, 48'h0000_DCD8_5DC0, 16'sh0, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh4000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh0000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh0000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh0000, 1'b0, 32'sd0},
    '{ROW_SAMPLE, CFG_FIRST_FF,  48'h0, 16'sh0000, 1'b0, 32'sd0}
  };

  localparam logic [COEF_W-1:0] CORNER_COEFS [0:5] = '{
    16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000
  };
  localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [0:4] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cbq_in_if  in_ch ();
  cbq_out_if out_ch ();

  cascaded_biquad_q14_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Filter model: coefficient registers and delay lines, at reset values
  logic [FF_W-1:0]            first_ff_q  = FF_RESET;
  logic [FB_W-1:0]            first_fb_q  = FB_RESET;
  logic [FF_W-1:0]            second_ff_q = FF_RESET;
  logic [FB_W-1:0]            second_fb_q = FB_RESET;
  logic signed [SAMPLE_W-1:0] first_x1  = '0, first_x2  = '0;
  logic signed [DATA_W-1:0]   first_y1  = '0, first_y2  = '0;
  logic signed [DATA_W-1:0]   second_x1 = '0, second_x2 = '0;
  logic signed [DATA_W-1:0]   second_y1 = '0, second_y2 = '0;

  logic signed [DATA_W-1:0] awaited_outputs [$];
  int                       mismatch_count = 0;
  int                       burst_left = 0;
  bit                       offering = 1'b0;
  bit                       holdoff_req = 1'b0;

  // One direct-form-I section. All operands are signed and 64 bits wide, so
  // every product is exact; the feedback terms are added. Keep bits
  // FRAC_BITS+31..FRAC_BITS, which is the arithmetic shift wrapped to 32 bits.
  function automatic logic signed [DATA_W-1:0] biquad_section(
      input logic [FF_W-1:0] ff, input logic [FB_W-1:0] fb,
      input longint x0, input longint x1, input longint x2,
      input longint y1, input longint y2);
    logic signed [63:0] acc;
    acc = x0 * $signed(ff[0 +: COEF_W])
        + x1 * $signed(ff[COEF_W +: COEF_W])
        + x2 * $signed(ff[2*COEF_W +: COEF_W])
        + y1 * $signed(fb[0 +: COEF_W])
        + y2 * $signed(fb[COEF_W +: COEF_W]);
    return acc[FRAC_BITS +: DATA_W];
  endfunction

  // Run one sample through both sections and advance the delay lines
  function automatic logic signed [DATA_W-1:0] filter_sample(
      input logic signed [SAMPLE_W-1:0] x);
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    y = biquad_section(first_ff_q, first_fb_q, x, first_x1, first_x2,
                       first_y1, first_y2);
    first_x2 = first_x1;
    first_x1 = x;
    first_y2 = first_y1;
    first_y1 = y;
    z = biquad_section(second_ff_q, second_fb_q, y, second_x1, second_x2,
                       second_y1, second_y2);
    second_x2 = second_x1;
    second_x1 = y;
    second_y2 = second_y1;
    second_y1 = z;
    return z;
  endfunction

  // Lower valid and park junk on the payload, unless already lowered
  task automatic drop_valid();
    if (offering) begin
      in_ch.valid     <= 1'b0;
      in_ch.sample_in <= SAMPLE_W'($urandom);
      offering = 1'b0;
    end
  endtask

  // Offer one item, wait for the handshake, then record what it must produce.
  // The sender runs in bursts: valid stays high from item to item until the
  // burst runs out, then a random gap follows (sometimes none at all).
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample,
                             input bit typed,
                             input logic signed [DATA_W-1:0] typed_out);
    logic signed [DATA_W-1:0] predicted;
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= sample;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // Always advance the model, even where the row carries its own answer
    predicted = filter_sample(sample);
    awaited_outputs.push_back(typed ? typed_out : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        drop_valid();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering, wait for every outstanding result, then let the core
  // finish whatever step it is on before anything touches its registers
  task automatic settle_block();
    drop_valid();
    @(posedge clk);
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write: drive the strobe, then release the strobe
  task automatic write_register(input cfg_idx_t idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    // feedback words are 32 bits wide; drop whatever sits above
    case (idx)
      CFG_FIRST_FF:  first_ff_q  = value[FF_W-1:0];
      CFG_FIRST_FB:  first_fb_q  = value[FB_W-1:0];
      CFG_SECOND_FF: second_ff_q = value[FF_W-1:0];
      CFG_SECOND_FB: second_fb_q = value[FB_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Compare every accepted result with the oldest outstanding expectation
  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (awaited_outputs.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: unexpected filtered_out %0d with nothing outstanding",
                   $time, out_ch.filtered_out);
        mismatch_count++;
      end else begin
        want = awaited_outputs.pop_front();
        if (out_ch.filtered_out !== want) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: filtered_out mismatch: expected %0d (%h), got %0d (%h)",
                     $time, want, want, out_ch.filtered_out, out_ch.filtered_out);
          mismatch_count++;
        end
      end
    end
  end

  // Result receiver: random segments of back-pressure, plus one long hold-off
  // on request so that the core fills up and has to refuse input for a while
  initial begin : receiver
    stall_mode_t mode;
    int span;
    int tick;
    forever begin
      if (holdoff_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_req = 1'b0;
      end
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 150);
      for (tick = 0; tick < span; tick++) begin
        case (mode)
          READY_ALWAYS:  out_ch.ready <= 1'b1;
          READY_RANDOM:  out_ch.ready <= 1'($urandom_range(0, 1));
          READY_PATTERN: out_ch.ready <= (tick % 5) != 0;
          default:       out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Hang detector: count cycles in which no item moves on either channel
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("cascaded_biquad_q14_filter_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    stim_row_t                  row;
    setting_kind_t              setting;
    logic [CFG_DATA_W-1:0]      value;
    logic [COEF_W-1:0]          coef;
    logic signed [SAMPLE_W-1:0] sample;
    int                         pick;
    int                         tap;
    bit                         prev_write;

    // Drive every input to a known value and hold reset
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= CFG_FIRST_FF;
    cfg_wdata       <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the table; drain the core before a group of writes
    prev_write = 1'b0;
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        if (!prev_write) settle_block();
        write_register(row.reg_sel, row.value);
      end else begin
        send_sample(row.sample, row.typed, row.typed_out);
      end
      prev_write = (row.kind == ROW_WRITE);
    end

    // Random part: each phase picks a fresh coefficient setting, writes all
    // four registers while idle, then streams samples through it
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_block();
      setting = setting_kind_t'($urandom_range(0, 3));
      tap = $urandom_range(0, 2);
      for (int r = 0; r < 4; r++) begin
        // odd indexes are feedback words; their top coefficient slot is junk
        for (int k = 0; k < 3; k++) begin
          case (setting)
            SET_RANDOM:
              coef = COEF_W'($urandom);
            SET_MILD:
              // feedback taps sum below one, so the cascade stays bounded
              coef = r[0] ? COEF_W'($urandom_range(0, 12000) - 6000)
                          : COEF_W'($urandom_range(0, 16384) - 8192);
            SET_EXTREME:
              coef = CORNER_COEFS[$urandom_range(0, 5)];
            default:
              coef = (k != tap) ? '0 :
                     !r[0] ? 16'h4000 :
                     ($urandom_range(0, 1) ? 16'h2000 : 16'hE000);
          endcase
          value[k*COEF_W +: COEF_W] = coef;
        end
        write_register(cfg_idx_t'(r), value);
      end

      if (phase == HOLDOFF_PHASE) holdoff_req = 1'b1;

      repeat (ITEMS_PER_PHASE) begin
        // mostly full-range samples, with corners, small values and impulses
        pick = $urandom_range(0, 99);
        if (pick < 55)
          sample = SAMPLE_W'($urandom);
        else if (pick < 70)
          sample = CORNER_SAMPLES[$urandom_range(0, 4)];
        else if (pick < 85)
          sample = SAMPLE_W'($urandom_range(0, 512) - 256);
        else
          sample = pick[0] ? 16'sh4000 : 16'shC000;
        send_sample(sample, 1'b0, '0);
      end
    end

    // Wait out the last results, then report
    settle_block();
    if (mismatch_count == 0 && awaited_outputs.size() == 0) begin
      $display("cascaded_biquad_q14_filter_core regression: pass");
    end else begin
      $display("cascaded_biquad_q14_filter_core regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/cbq_pkg.sv
src/cbq_if.sv
src/cascaded_biquad_q14_filter_core.sv
tb/testbench.sv
